// File: hdl/pf_pkg.sv
// ----------------------------------------------------------------------------
// pf_pkg: packet framer shared types and constants
// Word formats, register map, header layout and the CRC-16/XMODEM step.
// ----------------------------------------------------------------------------
package pf_pkg;

    // register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_VMAJ  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_VMIN  = 2'd2;

    localparam logic [7:0] CFG_START_RST = 8'h99;
    localparam logic [7:0] CFG_VMAJ_RST  = 8'h01;
    localparam logic [7:0] CFG_VMIN_RST  = 8'h00;

    // queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // header byte positions
    localparam int HDR_IDX_W = 4;
    localparam logic [HDR_IDX_W-1:0] HP_START0 = 4'd0;
    localparam logic [HDR_IDX_W-1:0] HP_START1 = 4'd1;
    localparam logic [HDR_IDX_W-1:0] HP_ID_HI  = 4'd2;
    localparam logic [HDR_IDX_W-1:0] HP_ID_LO  = 4'd3;
    localparam logic [HDR_IDX_W-1:0] HP_CMD    = 4'd4;
    localparam logic [HDR_IDX_W-1:0] HP_VMAJ   = 4'd5;
    localparam logic [HDR_IDX_W-1:0] HP_VMIN   = 4'd6;
    localparam logic [HDR_IDX_W-1:0] HP_LEN_HI = 4'd7;
    localparam logic [HDR_IDX_W-1:0] HP_LEN_LO = 4'd8;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [7:0]  command;
        logic [10:0] payload_length;
        logic        last_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } t_out_word;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] version_major;
        logic [7:0] version_minor;
    } t_cfg;

    typedef struct packed {
        t_in_word    word;
        logic        first;
        logic [15:0] pkt_id;
    } t_q_entry;

    typedef enum logic [2:0] {
        ST_NEW,
        ST_HDR,
        ST_DATA,
        ST_CRC_HI,
        ST_CRC_LO
    } t_bk_state;

    // one byte into CRC-16/XMODEM, msb first
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: hdl/pf_front.sv
// ----------------------------------------------------------------------------
// pf_front: input side of the packet framer
// Accepts words, marks the first word of each frame and assigns its id.
// ----------------------------------------------------------------------------
module pf_front import pf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_word i_in_word,
    input  logic     i_q_full,
    output logic     o_push,
    output t_q_entry o_entry
);

    logic        r_inside;
    logic [15:0] r_pkt_id;
    logic        n_inside;
    logic [15:0] n_pkt_id;
    logic        accept;

    always_comb begin
        accept   = i_in_valid && !i_q_full;
        n_inside = r_inside;
        n_pkt_id = r_pkt_id;
        o_entry.word   = i_in_word;
        o_entry.first  = !r_inside;
        o_entry.pkt_id = r_inside ? r_pkt_id : r_pkt_id + 16'd1;
        if (accept) begin
            n_inside = !i_in_word.last_byte;
            n_pkt_id = o_entry.pkt_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_pkt_id <= '0;
        end else begin
            r_inside <= n_inside;
            r_pkt_id <= n_pkt_id;
        end
    end

    assign o_push     = accept;
    assign o_in_stall = i_q_full;

endmodule

// File: hdl/pf_queue.sv
// ----------------------------------------------------------------------------
// pf_queue: small FIFO between front and back
// Holds classified words so the two sides stall independently.
// ----------------------------------------------------------------------------
module pf_queue import pf_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_head_valid,
    output t_q_entry o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_q_entry         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wp, n_rp;
    logic [CNT_W-1:0] n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    assign o_full       = (r_cnt == CNT_W'(DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

endmodule

// File: hdl/pf_back.sv
// ----------------------------------------------------------------------------
// pf_back: output sequencer of the packet framer
// Emits header, payload and CRC bytes, registered, one per unstalled cycle.
// ----------------------------------------------------------------------------
module pf_back import pf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_head_valid,
    input  t_q_entry  i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    t_bk_state            r_st, n_st, eff_st, nxt_st;
    logic [HDR_IDX_W-1:0] r_idx, n_idx, eff_idx, nxt_idx;
    logic [15:0]          r_crc, n_crc, crc_base;
    logic                 r_ov, n_ov;
    t_out_word            r_out, n_out;
    logic                 adv, fire, feed, done, fend;
    logic [7:0]           hdr_byte, byte_out;

    always_comb begin
        adv  = !r_ov || !i_out_stall;
        fire = i_head_valid && adv;

        eff_st  = r_st;
        eff_idx = r_idx;
        if (r_st == ST_NEW) begin
            eff_st  = i_head.first ? ST_HDR : ST_DATA;
            eff_idx = HP_START0;
        end
        // new frame restarts the CRC
        crc_base = (r_st == ST_NEW && i_head.first) ? '0 : r_crc;

        unique case (eff_idx)
            HP_START0, HP_START1: hdr_byte = i_cfg.start_byte;
            HP_ID_HI:             hdr_byte = i_head.pkt_id[15:8];
            HP_ID_LO:             hdr_byte = i_head.pkt_id[7:0];
            HP_CMD:               hdr_byte = i_head.word.command;
            HP_VMAJ:              hdr_byte = i_cfg.version_major;
            HP_VMIN:              hdr_byte = i_cfg.version_minor;
            HP_LEN_HI:            hdr_byte = {5'd0, i_head.word.payload_length[10:8]};
            HP_LEN_LO:            hdr_byte = i_head.word.payload_length[7:0];
            default:              hdr_byte = '0;
        endcase

        byte_out = '0;
        nxt_st   = r_st;
        nxt_idx  = r_idx;
        feed     = 1'b0;
        done     = 1'b0;
        fend     = 1'b0;
        unique case (eff_st)
            ST_NEW: begin
                nxt_st = ST_NEW;
            end
            ST_HDR: begin
                byte_out = hdr_byte;
                feed     = 1'b1;
                if (eff_idx == HP_LEN_LO) begin
                    nxt_st = ST_DATA;
                end else begin
                    nxt_st  = ST_HDR;
                    nxt_idx = eff_idx + 1'b1;
                end
            end
            ST_DATA: begin
                byte_out = i_head.word.data_byte;
                feed     = 1'b1;
                if (i_head.word.last_byte) begin
                    nxt_st = ST_CRC_HI;
                end else begin
                    nxt_st = ST_NEW;
                    done   = 1'b1;
                end
            end
            ST_CRC_HI: begin
                byte_out = r_crc[15:8];
                nxt_st   = ST_CRC_LO;
            end
            ST_CRC_LO: begin
                byte_out = r_crc[7:0];
                nxt_st   = ST_NEW;
                done     = 1'b1;
                fend     = 1'b1;
            end
            default: begin
                nxt_st = ST_NEW;
            end
        endcase

        n_st  = r_st;
        n_idx = r_idx;
        n_crc = r_crc;
        n_out = r_out;
        n_ov  = r_ov && i_out_stall;
        if (fire) begin
            n_st  = nxt_st;
            n_idx = nxt_idx;
            n_ov  = 1'b1;
            n_out.out_byte  = byte_out;
            n_out.run_last  = done;
            n_out.frame_end = fend;
            if (feed) begin
                n_crc = crc16_feed(crc_base, byte_out);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_NEW;
            r_idx <= '0;
            r_crc <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_idx <= n_idx;
            r_crc <= n_crc;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_pop       = fire && done;
    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

    a_crc_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_CRC_LO && $past(r_st) != ST_CRC_LO) |-> $past(r_st) == ST_CRC_HI)
        else $error("low CRC byte not preceded by high CRC byte");

endmodule

// File: hdl/packet_framer_crc16_core.sv
// ----------------------------------------------------------------------------
// packet_framer_crc16_core: byte stream framer with CRC-16/XMODEM trailer
// Front classifier, word queue and output sequencer; three config registers.
// ----------------------------------------------------------------------------
// Each input word carries one payload byte. The first word of a frame yields
// ten output words: start byte twice, packet id (high, low), command, major
// and minor version, payload length (high, low) and the byte itself. Later
// words yield one output word each; a word marked last adds the CRC-16/XMODEM
// of header plus payload, high byte first, with frame_end on the low byte.
// Command and length are sampled from the first word only. The packet id
// counts from 1 after reset and wraps at 16 bits.
// The output sequencer emits one word per cycle unless the queue is empty or
// i_out_stall holds it. A QUEUE_DEPTH-entry queue (default 4) lets input
// keep flowing during the header and CRC bursts until it fills. Output is
// registered; the sequencer holds its place while the current word waits
// on i_out_stall.
// Config registers (0 start_byte, 1 version_major, 2 version_minor) are
// written through the cfg port, always ready; write only while idle.
module packet_framer_crc16_core import pf_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    // output words
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word,
    // config writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    t_cfg     r_cfg;
    logic     q_push, q_pop, q_full, q_head_valid;
    t_q_entry q_entry, q_head;

    // config registers; unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte    <= CFG_START_RST;
            r_cfg.version_major <= CFG_VMAJ_RST;
            r_cfg.version_minor <= CFG_VMIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_START: r_cfg.start_byte    <= i_cfg_data;
                CFG_IDX_VMAJ:  r_cfg.version_major <= i_cfg_data;
                CFG_IDX_VMIN:  r_cfg.version_minor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // front: frame tracking and packet id
    pf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_entry    (q_entry)
    );

    // decoupling queue
    pf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_entry      (q_entry),
        .i_pop        (q_pop),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    // back: header / payload / CRC sequencer
    pf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .o_out_word   (o_out_word),
        .i_out_stall  (i_out_stall)
    );

    a_fend_closes_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.frame_end) |-> o_out_word.run_last)
        else $error("frame_end without run_last");

    a_pop_shows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (o_out_valid && o_out_word.run_last))
        else $error("queue pop without closing output word");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_head_valid |-> !o_in_stall)
        else $error("input stalled with empty queue");

endmodule
